// File: sv/pid_pkg.sv
// shared types, codes and constants of the polytope interior distance block
// depends on nothing; every other file of the block but pid_ram imports it
package pid_pkg;

   // fixed field widths
   localparam int COORD_WIDTH    = 16;
   localparam int OFFSET_WIDTH   = 32;
   localparam int DIST_WIDTH     = 36;
   localparam int INDEX_WIDTH    = 6;
   localparam int DIM_WIDTH      = 2;
   localparam int COUNT_WIDTH    = 7;
   localparam int CSR_DATA_WIDTH = 7;
   localparam int CSR_INDEX_WIDTH = 1;

   // parameter defaults
   localparam int MAX_FACETS_DEFAULT = 64;
   localparam int MAX_DIM_DEFAULT    = 3;

   // reset values of the registers
   localparam logic [DIM_WIDTH-1:0]   DIMENSION_RESET   = 2'd3;
   localparam logic [COUNT_WIDTH-1:0] FACET_COUNT_RESET = 7'd1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DIMENSION   = 1'b0,
      CSR_FACET_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic {
      KIND_QUERY = 1'b0,
      KIND_WRITE = 1'b1
   } kind_type;

   typedef struct packed {
      op_type                          op;
      logic [INDEX_WIDTH-1:0]          facet_index;
      logic signed [COORD_WIDTH-1:0]   coord_a;
      logic signed [COORD_WIDTH-1:0]   coord_b;
      logic signed [COORD_WIDTH-1:0]   coord_c;
      logic signed [OFFSET_WIDTH-1:0]  offset;
   } req_type;

   typedef struct packed {
      logic signed [DIST_WIDTH-1:0] distance;
      logic                         outside;
      kind_type                     kind;
   } rsp_type;

   // sequencer states
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_WALK,
      SEQ_DRAIN
   } seq_state_type;

   // travels with each facet read through the evaluation pipeline
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } seq_tag_type;

   typedef struct packed {
      logic                         done;
      logic signed [DIST_WIDTH-1:0] distance;
   } eval_result_type;

   // number of normal components stored per facet
   function automatic int comp_count(input int max_dim);
      return (max_dim < 3) ? max_dim : 3;
   endfunction

endpackage

// File: sv/pid_ram.sv
// generic single-clock ram, one write port and one registered read port
// depends on nothing
module pid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/pid_seq.sv
// facet walk sequencer: issues table addresses and pipeline tags for a query
// depends on pid_pkg
module pid_seq #(
   parameter int MAX_FACETS = pid_pkg::MAX_FACETS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start_query,
   input  logic [$clog2(MAX_FACETS)-1:0] last_index,
   input  logic                          done,
   output logic                          busy,
   output logic [$clog2(MAX_FACETS)-1:0] rd_addr,
   output pid_pkg::seq_tag_type          tag
);
   import pid_pkg::*;

   localparam int AW = $clog2(MAX_FACETS);

   seq_state_type state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;

   // next state
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (start_query) begin
               state_in = SEQ_WALK;
               addr_in  = '0;
            end
         end
         SEQ_WALK: begin
            if (addr_ff == last_index) begin
               state_in = SEQ_DRAIN;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         SEQ_DRAIN: begin
            if (done) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy      = 1'b1;
      tag.valid = 1'b0;
      tag.first = 1'b0;
      tag.last  = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            busy = 1'b0;
         end
         SEQ_WALK: begin
            tag.valid = 1'b1;
            tag.first = (addr_ff == '0);
            tag.last  = (addr_ff == last_index);
         end
         SEQ_DRAIN: begin
            busy = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assign rd_addr = addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

endmodule

// File: sv/pid_eval.sv
// evaluation pipeline: per-facet dot product, offset difference, running minimum
// depends on pid_pkg; fed by the facet tables and the sequencer tags
module pid_eval #(
   parameter int MAX_DIM = pid_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  pid_pkg::seq_tag_type                    tag,
   input  logic [pid_pkg::comp_count(MAX_DIM)*pid_pkg::COORD_WIDTH-1:0] normal_data,
   input  logic signed [pid_pkg::OFFSET_WIDTH-1:0] offset_data,
   input  logic [pid_pkg::comp_count(MAX_DIM)*pid_pkg::COORD_WIDTH-1:0] point,
   output pid_pkg::eval_result_type                result
);
   import pid_pkg::*;

   localparam int NCOMP = comp_count(MAX_DIM);
   localparam int CW    = COORD_WIDTH;
   localparam int PW    = 2 * COORD_WIDTH;
   localparam int DW    = DIST_WIDTH;

   seq_tag_type tag1_ff, tag2_ff, tag3_ff;

   logic signed [CW-1:0] nrm [NCOMP];
   logic signed [CW-1:0] pt  [NCOMP];
   logic signed [PW-1:0] prod_in [NCOMP];
   logic signed [PW-1:0] prod_ff [NCOMP];
   logic signed [OFFSET_WIDTH-1:0] off2_ff;
   logic signed [DW-1:0] acc;
   logic signed [DW-1:0] dist_in, dist3_ff;
   logic signed [DW-1:0] best_in, best_ff;
   logic                 take;

   // stage 1: table data is here, one multiplier per component
   always_comb begin
      for (int k = 0; k < NCOMP; k++) begin
         nrm[k]     = signed'(normal_data[k*CW +: CW]);
         pt[k]      = signed'(point[k*CW +: CW]);
         prod_in[k] = nrm[k] * pt[k];
      end
   end

   // stage 2: offset minus dot product at the result width, which the sums cannot overflow
   always_comb begin
      acc = '0;
      for (int k = 0; k < NCOMP; k++) begin
         acc = acc + DW'(prod_ff[k]);
      end
      dist_in = DW'(off2_ff) - acc;
   end

   // stage 3: running minimum, first facet always taken
   always_comb begin
      take    = tag3_ff.first || (dist3_ff < best_ff);
      best_in = take ? dist3_ff : best_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      off2_ff  <= offset_data;
      dist3_ff <= dist_in;
      if (tag3_ff.valid) begin
         best_ff <= best_in;
      end
   end

   assign result.done     = tag3_ff.valid && tag3_ff.last;
   assign result.distance = best_in;

endmodule

// File: sv/polytope_interior_distance_top.sv
// top level of the polytope interior distance block
// depends on pid_pkg, pid_ram, pid_seq and pid_eval
//
// writes are acknowledged on the cycle after acceptance, one per cycle while no query is busy
// a query walks the active facets, one table read per cycle; the result passes the address,
// table read, product, distance and response registers; busy drops as the result is strobed
// synchronous active-high reset clears the registers (dimension 3, facet count 1) and the
// sequencer; the facet tables are not cleared and hold nothing until written
// results are strobed for one cycle and the receiver cannot stall them
module polytope_interior_distance_top #(
   parameter int MAX_FACETS = pid_pkg::MAX_FACETS_DEFAULT,
   parameter int MAX_DIM    = pid_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request transaction
   input  logic                                   start,
   output logic                                   busy,
   input  pid_pkg::req_type                       req_data,
   // response transaction
   output logic                                   rsp_strobe,
   output pid_pkg::rsp_type                       rsp_data,
   // register writes
   input  logic                                   csr_we,
   input  logic [pid_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [pid_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import pid_pkg::*;

   localparam int AW    = $clog2(MAX_FACETS);
   localparam int NCOMP = comp_count(MAX_DIM);
   localparam int CW    = COORD_WIDTH;
   localparam int NW    = NCOMP * CW;

   // configuration registers
   logic [DIM_WIDTH-1:0]   dimension_ff;
   logic [COUNT_WIDTH-1:0] facet_count_ff;

   // effective settings after clamping
   logic [DIM_WIDTH-1:0] dim_eff;
   logic [AW-1:0]        last_index;

   // request decode
   logic accept, accept_write, accept_query, table_hit;
   logic signed [CW-1:0] req_comp [3];

   // query point, unused coordinates forced to zero
   logic [NW-1:0] point_ff, point_in;
   logic [NW-1:0] normal_wr;

   // table read side
   logic [AW-1:0]              rd_addr;
   logic [NW-1:0]              normal_rd;
   logic [OFFSET_WIDTH-1:0]    offset_rd;

   seq_tag_type     tag;
   eval_result_type eval_result;

   // response register
   logic    rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // register writes, taken whenever the enable is high
   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff   <= DIMENSION_RESET;
         facet_count_ff <= FACET_COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DIMENSION:   dimension_ff   <= csr_wdata[DIM_WIDTH-1:0];
            CSR_FACET_COUNT: facet_count_ff <= csr_wdata[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // dimension zero counts as one, above the stored components it saturates
   always_comb begin
      if (dimension_ff == '0) begin
         dim_eff = DIM_WIDTH'(1);
      end else if (int'(dimension_ff) > NCOMP) begin
         dim_eff = DIM_WIDTH'(NCOMP);
      end else begin
         dim_eff = dimension_ff;
      end
   end

   // facet count zero counts as one, above the table depth it saturates
   always_comb begin
      if (facet_count_ff == '0) begin
         last_index = '0;
      end else if (int'(facet_count_ff) > MAX_FACETS) begin
         last_index = AW'(MAX_FACETS - 1);
      end else begin
         last_index = AW'(facet_count_ff - COUNT_WIDTH'(1));
      end
   end

   assign accept       = start && !busy;
   assign accept_write = accept && (req_data.op == OP_WRITE);
   assign accept_query = accept && (req_data.op == OP_QUERY);
   // an entry past the table end stores nothing but is still acknowledged
   assign table_hit    = int'(req_data.facet_index) < MAX_FACETS;

   assign req_comp[0] = req_data.coord_a;
   assign req_comp[1] = req_data.coord_b;
   assign req_comp[2] = req_data.coord_c;

   always_comb begin
      for (int k = 0; k < NCOMP; k++) begin
         normal_wr[k*CW +: CW] = req_comp[k];
         point_in[k*CW +: CW]  = (k < int'(dim_eff)) ? req_comp[k] : '0;
      end
   end

   // point held for the whole facet walk
   always_ff @(posedge clock) begin
      if (accept_query) begin
         point_ff <= point_in;
      end
   end

   pid_ram #(
      .WIDTH (NW),
      .DEPTH (MAX_FACETS)
   ) u_normal_ram (
      .clock   (clock),
      .wr_en   (accept_write && table_hit),
      .wr_addr (AW'(req_data.facet_index)),
      .wr_data (normal_wr),
      .rd_addr (rd_addr),
      .rd_data (normal_rd)
   );

   pid_ram #(
      .WIDTH (OFFSET_WIDTH),
      .DEPTH (MAX_FACETS)
   ) u_offset_ram (
      .clock   (clock),
      .wr_en   (accept_write && table_hit),
      .wr_addr (AW'(req_data.facet_index)),
      .wr_data (req_data.offset),
      .rd_addr (rd_addr),
      .rd_data (offset_rd)
   );

   // walks facets 0 .. last_index, one read per cycle, then waits for the minimum
   pid_seq #(
      .MAX_FACETS (MAX_FACETS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start_query (accept_query),
      .last_index  (last_index),
      .done        (eval_result.done),
      .busy        (busy),
      .rd_addr     (rd_addr),
      .tag         (tag)
   );

   pid_eval #(
      .MAX_DIM (MAX_DIM)
   ) u_eval (
      .clock       (clock),
      .reset       (reset),
      .tag         (tag),
      .normal_data (normal_rd),
      .offset_data (signed'(offset_rd)),
      .point       (point_ff),
      .result      (eval_result)
   );

   // write ack and query result cannot meet: busy holds off requests until the result
   always_comb begin
      rsp_strobe_in        = 1'b0;
      rsp_data_in.distance = '0;
      rsp_data_in.outside  = 1'b0;
      rsp_data_in.kind     = KIND_WRITE;
      if (accept_write) begin
         rsp_strobe_in = 1'b1;
      end else if (eval_result.done) begin
         rsp_strobe_in        = 1'b1;
         rsp_data_in.distance = eval_result.distance;
         rsp_data_in.outside  = eval_result.distance[DIST_WIDTH-1];
         rsp_data_in.kind     = KIND_QUERY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // write transaction is acknowledged on the next cycle
   a_write_ack: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.op == OP_WRITE) |=>
      (rsp_strobe && rsp_data.kind == KIND_WRITE))
      else $error("write transaction not acknowledged on the next cycle");

   // a query holds off further requests
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.op == OP_QUERY) |=> busy)
      else $error("query accepted without going busy");

   // the minimum completes only inside a facet walk
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      eval_result.done |-> busy)
      else $error("evaluation finished while sequencer idle");

   // a query result appears once the sequencer has let go
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.kind == KIND_QUERY) |-> !busy)
      else $error("query result strobed while still busy");

endmodule

// File: dv/polytope_interior_distance_top_test.sv
`timescale 1ns / 100ps
// testbench for polytope_interior_distance_top: facet writes and point queries
// against a behavioral predictor; depends only on pid_pkg and the block itself
module polytope_interior_distance_top_test;
   import pid_pkg::*;

   localparam int FACETS         = MAX_FACETS_DEFAULT;
   localparam int DIMS           = MAX_DIM_DEFAULT;
   localparam int SETTLE_CYCLES  = 4;     // every item has a result, so little slack needed
   localparam int FINAL_CYCLES   = 80;    // longest query walks all 64 facets
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int MAX_PRINTED    = 40;
   localparam logic signed [COORD_WIDTH-1:0] ONE_Q14 = 16'sd16384;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   // predictor state: facet table and register copies
   logic signed [COORD_WIDTH-1:0]  facet_normals [FACETS][3];
   logic signed [OFFSET_WIDTH-1:0] facet_offsets [FACETS];
   logic [DIM_WIDTH-1:0]           cfg_dimension   = DIMENSION_RESET;
   logic [COUNT_WIDTH-1:0]         cfg_facet_count = FACET_COUNT_RESET;

   // responses still owed by the block, oldest first
   rsp_type due_distances [$];
   int      error_count     = 0;
   int      sender_idle_pct = 0;

   polytope_interior_distance_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------- predictor

   // applies one accepted transaction to the facet table copy and returns
   // the response the block owes for it
   function automatic rsp_type apply_facet_request(input req_type item);
      rsp_type                       answer;
      logic signed [COORD_WIDTH-1:0] point [3];
      int unsigned                   dims;
      int unsigned                   count;
      longint                        dot;
      longint                        margin;
      longint                        nearest;
      answer   = '0;
      point[0] = item.coord_a;
      point[1] = item.coord_b;
      point[2] = item.coord_c;
      if (item.op == OP_WRITE) begin
         // out-of-range index is acknowledged but stores nothing
         if (item.facet_index < FACETS) begin
            for (int k = 0; k < 3; k++) facet_normals[item.facet_index][k] = point[k];
            facet_offsets[item.facet_index] = item.offset;
         end
         answer.kind = KIND_WRITE;
      end else begin
         // zero dimension acts as one, large values saturate
         dims = (cfg_dimension == 0) ? 1 : cfg_dimension;
         if (dims > DIMS) dims = DIMS;
         if (dims > 3) dims = 3;
         // zero count acts as one, counts past the table saturate
         count = (cfg_facet_count == 0) ? 1 : cfg_facet_count;
         if (count > FACETS) count = FACETS;
         nearest = 0;
         for (int i = 0; i < count; i++) begin
            dot = 0;
            for (int k = 0; k < dims; k++)
               dot += longint'(facet_normals[i][k]) * longint'(point[k]);
            margin = longint'(facet_offsets[i]) - dot;
            if (i == 0 || margin < nearest) nearest = margin;
         end
         answer.distance = nearest[DIST_WIDTH-1:0];
         answer.outside  = (nearest < 0);
         answer.kind     = KIND_QUERY;
      end
      return answer;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string field, input longint got, input longint want);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("%0t: %s mismatch, got %0d, want %0d", $time, field, got, want);
   endtask

   // results cannot be held off: each strobed cycle is one response
   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (due_distances.size() == 0) begin
            report_mismatch("unrequested response", longint'(rsp_data.distance), 0);
         end else begin
            want = due_distances.pop_front();
            if (rsp_data.distance !== want.distance)
               report_mismatch("distance", longint'(rsp_data.distance),
                               longint'(want.distance));
            if (rsp_data.outside !== want.outside)
               report_mismatch("outside", longint'(rsp_data.outside),
                               longint'(want.outside));
            if (rsp_data.kind !== want.kind)
               report_mismatch("kind", longint'(rsp_data.kind), longint'(want.kind));
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // start is left high on return so a back-to-back transaction keeps it up;
   // anything that lets time pass afterwards must lower it first
   task automatic send_item(input req_type item);
      int gap;
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         gap = $urandom_range(1, 5);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      // accepted at this edge
      due_distances.push_back(apply_facet_request(item));
   endtask

   // sender pauses until every owed response has come back
   task automatic wait_until_drained(input int settle);
      start <= 1'b0;
      while (due_distances.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // both registers, written back to back while the block is idle
   task automatic set_config(input logic [CSR_DATA_WIDTH-1:0] dim_value,
                             input logic [CSR_DATA_WIDTH-1:0] count_value);
      wait_until_drained(SETTLE_CYCLES);
      csr_we    <= 1'b1;
      csr_index <= CSR_DIMENSION;
      csr_wdata <= dim_value;
      @(posedge clock);
      cfg_dimension = dim_value[DIM_WIDTH-1:0];
      csr_index <= CSR_FACET_COUNT;
      csr_wdata <= count_value;
      @(posedge clock);
      cfg_facet_count = count_value[COUNT_WIDTH-1:0];
      csr_we <= 1'b0;
   endtask

   function automatic req_type make_write(input logic [INDEX_WIDTH-1:0] index,
                                          input logic signed [COORD_WIDTH-1:0] a,
                                          input logic signed [COORD_WIDTH-1:0] b,
                                          input logic signed [COORD_WIDTH-1:0] c,
                                          input logic signed [OFFSET_WIDTH-1:0] offset);
      req_type item;
      item.op          = OP_WRITE;
      item.facet_index = index;
      item.coord_a     = a;
      item.coord_b     = b;
      item.coord_c     = c;
      item.offset      = offset;
      return item;
   endfunction

   // index and offset are unused on a query, so they carry noise
   function automatic req_type make_query(input logic signed [COORD_WIDTH-1:0] a,
                                          input logic signed [COORD_WIDTH-1:0] b,
                                          input logic signed [COORD_WIDTH-1:0] c);
      req_type item;
      item.op          = OP_QUERY;
      item.facet_index = INDEX_WIDTH'($urandom);
      item.coord_a     = a;
      item.coord_b     = b;
      item.coord_c     = c;
      item.offset      = $urandom;
      return item;
   endfunction

   // mostly full range, with a share of extremes and of small values near the origin
   function automatic logic signed [COORD_WIDTH-1:0] random_coord();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5)  return 16'sh8000;
      if (pick < 10) return 16'sh7fff;
      if (pick < 13) return '0;
      if (pick < 40) return COORD_WIDTH'($signed($urandom_range(128)) - 64);
      return COORD_WIDTH'($urandom);
   endfunction

   function automatic logic signed [OFFSET_WIDTH-1:0] random_offset();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5)  return 32'sh8000_0000;
      if (pick < 10) return 32'sh7fff_ffff;
      if (pick < 40) return OFFSET_WIDTH'($signed($urandom_range(1 << 22)) - (1 << 21));
      return $urandom;
   endfunction

   // ---------------------------------------------------------------- tests

   // registers at reset values: three dimensions, one facet
   task automatic test_reset_registers();
      send_item(make_write(0, ONE_Q14, 0, 0, 100 * 16384));
      send_item(make_query(10, 5, -3));
      send_item(make_query(16'sh7fff, 16'sh8000, 16'sh7fff));
   endtask

   // extreme normals and offsets, points at the corners of the range
   task automatic test_extreme_facets();
      send_item(make_write(0, 16'sh8000, 16'sh8000, 16'sh8000, 32'sh8000_0000));
      send_item(make_write(1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sh7fff_ffff));
      send_item(make_write(2, 0, ONE_Q14, 0, 0));
      send_item(make_write(3, -ONE_Q14, 0, ONE_Q14, 12345));
      set_config(CSR_DATA_WIDTH'(DIMS), 4);
      send_item(make_query(16'sh8000, 16'sh8000, 16'sh8000));
      send_item(make_query(16'sh7fff, 16'sh7fff, 16'sh7fff));
      send_item(make_query(0, 0, 0));
   endtask

   // coordinates past the dimension drop out; zero dimension acts as one
   task automatic test_dimensions();
      for (int d = 1; d <= 4; d++) begin
         set_config(CSR_DATA_WIDTH'(d % 4), 4);
         send_item(make_query(1000, -2000, 3000));
      end
   endtask

   // zero facet count acts as one; point on the plane and just past it
   task automatic test_facet_count_zero();
      send_item(make_write(0, ONE_Q14, 0, 0, 5 * 16384));
      set_config(CSR_DATA_WIDTH'(DIMS), 0);
      send_item(make_query(5, random_coord(), random_coord()));
      send_item(make_query(6, random_coord(), random_coord()));
   endtask

   // fills every entry, then counts at and past the table size
   task automatic test_full_table();
      logic [COUNT_WIDTH-1:0] counts [3];
      counts = '{7'd64, 7'd127, 7'd65};
      for (int i = 0; i < FACETS; i++)
         send_item(make_write(INDEX_WIDTH'(i), random_coord(), random_coord(),
                              random_coord(), random_offset()));
      foreach (counts[j]) begin
         set_config(CSR_DATA_WIDTH'(DIMS), counts[j]);
         send_item(make_query(random_coord(), random_coord(), random_coord()));
      end
   endtask

   // mixed writes and queries; registers change every hundred transactions,
   // mostly to small facet counts so queries stay short
   task automatic test_random_traffic(input int idle_pct, input int item_count);
      logic [CSR_DATA_WIDTH-1:0] dim_value;
      logic [CSR_DATA_WIDTH-1:0] count_value;
      int                        pick;
      sender_idle_pct = idle_pct;
      for (int n = 0; n < item_count; n++) begin
         if (n % 100 == 0) begin
            // upper data bits are junk for the dimension register
            dim_value      = CSR_DATA_WIDTH'($urandom);
            dim_value[1:0] = 2'($urandom_range(3));
            pick = $urandom_range(99);
            if (pick < 80)      count_value = CSR_DATA_WIDTH'($urandom_range(1, 8));
            else if (pick < 90) count_value = CSR_DATA_WIDTH'($urandom_range(9, 64));
            else if (pick < 94) count_value = '0;
            else                count_value = CSR_DATA_WIDTH'($urandom_range(64, 127));
            set_config(dim_value, count_value);
         end else if (n == item_count / 2 + 7) begin
            wait_until_drained(0);
         end
         if ($urandom_range(99) < 30)
            send_item(make_write(INDEX_WIDTH'($urandom), random_coord(), random_coord(),
                                 random_coord(), random_offset()));
         else
            send_item(make_query(random_coord(), random_coord(), random_coord()));
      end
      wait_until_drained(SETTLE_CYCLES);
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_DIMENSION;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_registers();
      test_extreme_facets();
      test_dimensions();
      test_facet_count_zero();
      test_full_table();
      // sender idles often, then more, then not at all
      test_random_traffic(31, 600);
      test_random_traffic(50, 600);
      test_random_traffic(0, 600);

      wait_until_drained(FINAL_CYCLES);
      if (error_count == 0 && due_distances.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog in case the block hangs
   initial begin
      #(TIMEOUT_CYCLES * 10);
      $display("Test completed with failures");
      $finish;
   end

endmodule
